### sv/elevator_look_controller_top_assert.svh
// Assertion macros for the LOOK elevator controller.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ELEVATOR_LOOK_CONTROLLER_TOP_ASSERT_SVH
`define ELEVATOR_LOOK_CONTROLLER_TOP_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define ELC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define ELC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ELC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/elc_pkg.sv
// ----------------------------------------------------------------------------
// elc_pkg
// Codes, register indexes and reset values for the LOOK elevator controller.
// ----------------------------------------------------------------------------
package elc_pkg;

	localparam int unsigned FLOORS_DEF = 16;

	localparam int unsigned FLOOR_W = 5;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned TALLY_W = 5;

	typedef logic [2:0]             opcode_t;
	typedef logic [1:0]             dir_t;
	typedef logic [1:0]             mode_t;
	typedef logic [FLOOR_W-1:0]     floor_t;
	typedef logic [TIME_W-1:0]      stamp_t;
	typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
	typedef logic [TALLY_W-1:0]     tally_t;

	// opcodes
	localparam opcode_t OP_TICK  = 3'd0;
	localparam opcode_t OP_CABIN = 3'd1;
	localparam opcode_t OP_UP    = 3'd2;
	localparam opcode_t OP_DOWN  = 3'd3;
	localparam opcode_t OP_RESET = 3'd4;

	// travel direction
	localparam dir_t DIR_NONE = 2'd0;
	localparam dir_t DIR_UP   = 2'd1;
	localparam dir_t DIR_DESC = 2'd2;

	// control mode
	localparam mode_t MODE_IDLE  = 2'd0;
	localparam mode_t MODE_MOVE  = 2'd1;
	localparam mode_t MODE_BLINK = 2'd2;
	localparam mode_t MODE_DOOR  = 2'd3;

	// register indexes
	localparam cfg_idx_t REG_MOVE_TIME  = 2'd0;
	localparam cfg_idx_t REG_BLINK_INTV = 2'd1;
	localparam cfg_idx_t REG_BLINK_CYC  = 2'd2;
	localparam cfg_idx_t REG_DOOR_TIME  = 2'd3;

	// register reset values
	localparam logic [15:0] MOVE_TIME_RST  = 16'd2000;
	localparam logic [15:0] BLINK_INTV_RST = 16'd500;
	localparam logic [3:0]  BLINK_CYC_RST  = 4'd3;
	localparam logic [15:0] DOOR_TIME_RST  = 16'd3000;

	localparam floor_t FLOOR_BOTTOM = 5'd1;

endpackage

### sv/elevator_look_controller_top.sv
// ----------------------------------------------------------------------------
// elevator_look_controller_top
// LOOK scheduling elevator controller: call registers, car motion, arrival
// lamp blinking and door timing, one event or tick per transfer.
// ----------------------------------------------------------------------------
// Usage:
// Input channel (in_valid / in_stall) carries one event per transfer: a tick
// with its millisecond time, a cabin or hall call, or a soft reset. Output
// channel (out_valid / out_stall) returns exactly one status transfer per
// event: car floor, direction, mode, lamp, rejected-call flag and pending
// flag, all taken after the event has been applied.
// Path: an event is captured in the input register, then the scheduler logic
// writes the state and the result register at the same edge, which raises
// out_valid; a held result can keep the event waiting in the input register.
// One event is taken every cycle while the output is free;
// the rate is set by the single-cycle state update loop.
// When the receiver stalls, the result register holds and the input register
// stays full, so in_stall rises in the same cycle and no event is lost.
// Timing registers are written through cfg_wr_en / cfg_index / cfg_data.
// After arst_n: no calls, car at floor 1, stopped, idle, timing registers at
// their defaults, both channels empty.
// ----------------------------------------------------------------------------
`include "elevator_look_controller_top_assert.svh"

module elevator_look_controller_top
	import elc_pkg::*;
#(
	parameter int unsigned FLOORS = FLOORS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           opcode,
	input  logic [4:0]           floor_number,
	input  logic [31:0]          now_ms,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [4:0]           car_floor,
	output logic [1:0]           travel_direction,
	output logic [1:0]           control_mode,
	output logic                 lamp_on,
	output logic                 call_rejected,
	output logic                 calls_pending
);

	localparam floor_t FLOOR_TOP = FLOOR_W'(FLOORS);

	typedef logic [FLOORS:1] calls_t;

	// configuration registers
	logic [15:0] move_time_q, blink_intv_q, door_time_q;
	logic [3:0]  blink_cyc_q;

	// input stage
	logic    valid_s1;
	opcode_t opcode_s1;
	floor_t  floor_s1;
	stamp_t  now_s1;

	// scheduler state
	calls_t cab_q, up_q, dn_q;
	floor_t floor_q;
	dir_t   dir_q;
	mode_t  mode_q;
	stamp_t move_stamp_q, blink_stamp_q, door_stamp_q;
	tally_t tally_q;
	logic   lamp_q;

	// result stage
	logic   valid_s2;
	floor_t floor_s2;
	dir_t   dir_s2;
	mode_t  mode_s2;
	logic   lamp_s2, rej_s2, pend_s2;

	logic advance;

	// next state
	calls_t cab_d, up_d, dn_d;
	floor_t floor_d;
	dir_t   dir_d;
	mode_t  mode_d;
	stamp_t move_stamp_d, blink_stamp_d, door_stamp_d;
	tally_t tally_d;
	logic   lamp_d, rej_d;

	// floor masks for the current floor and the floor after one move
	calls_t all_c, here_c, above_c, here_n, above_n, below_n, req_bit;
	floor_t nf;
	logic   move_due, blink_due, door_due, can_move, beyond_n, stop_n;
	tally_t tally_inc;
	logic [TALLY_W:0] blink_limit;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_time_q  <= MOVE_TIME_RST;
			blink_intv_q <= BLINK_INTV_RST;
			blink_cyc_q  <= BLINK_CYC_RST;
			door_time_q  <= DOOR_TIME_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MOVE_TIME:  move_time_q  <= cfg_data;
				REG_BLINK_INTV: blink_intv_q <= cfg_data;
				REG_BLINK_CYC:  blink_cyc_q  <= cfg_data[3:0];
				REG_DOOR_TIME:  door_time_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1 <= opcode;
			floor_s1  <= floor_number;
			now_s1    <= now_ms;
		end
	end

	always_comb begin
		all_c = cab_q | up_q | dn_q;
		nf    = (dir_q == DIR_UP) ? floor_q + 5'd1 : floor_q - 5'd1;
		for (int i = 1; i <= FLOORS; i++) begin
			here_c[i]  = (floor_q == FLOOR_W'(i));
			above_c[i] = (FLOOR_W'(i) > floor_q);
			here_n[i]  = (nf == FLOOR_W'(i));
			above_n[i] = (FLOOR_W'(i) > nf);
			below_n[i] = (FLOOR_W'(i) < nf);
			req_bit[i] = (floor_s1 == FLOOR_W'(i));
		end
	end

	always_comb begin
		move_due  = (now_s1 - move_stamp_q) >= {16'd0, move_time_q};
		blink_due = (now_s1 - blink_stamp_q) >= {16'd0, blink_intv_q};
		door_due  = (now_s1 - door_stamp_q) >= {16'd0, door_time_q};
		can_move  = (dir_q == DIR_UP && floor_q < FLOOR_TOP) ||
			(dir_q == DIR_DESC && floor_q > FLOOR_BOTTOM);
		beyond_n  = (dir_q == DIR_UP)   ? |(all_c & above_n) :
			(dir_q == DIR_DESC) ? |(all_c & below_n) : 1'b0;
		// hall call against travel only counts when nothing lies further on
		stop_n    = |(cab_q & here_n) ||
			(dir_q == DIR_UP &&
				(|(up_q & here_n) || (|(dn_q & here_n) && !beyond_n))) ||
			(dir_q == DIR_DESC &&
				(|(dn_q & here_n) || (|(up_q & here_n) && !beyond_n)));
		tally_inc   = tally_q + 5'd1;
		blink_limit = {1'b0, blink_cyc_q, 1'b0};
	end

	always_comb begin
		cab_d         = cab_q;
		up_d          = up_q;
		dn_d          = dn_q;
		floor_d       = floor_q;
		dir_d         = dir_q;
		mode_d        = mode_q;
		move_stamp_d  = move_stamp_q;
		blink_stamp_d = blink_stamp_q;
		door_stamp_d  = door_stamp_q;
		tally_d       = tally_q;
		lamp_d        = lamp_q;
		rej_d         = 1'b0;
		case (opcode_s1)
			OP_TICK: begin
				case (mode_q)
					MODE_IDLE: begin
						if (|(all_c & here_c)) begin
							cab_d   = cab_q & ~here_c;
							up_d    = up_q & ~here_c;
							dn_d    = dn_q & ~here_c;
							mode_d  = MODE_BLINK;
							tally_d = '0;
						end else if (|all_c) begin
							dir_d        = |(all_c & above_c) ? DIR_UP : DIR_DESC;
							mode_d       = MODE_MOVE;
							move_stamp_d = now_s1;
						end else begin
							dir_d = DIR_NONE;
						end
					end
					MODE_MOVE: begin
						if (move_due) begin
							if (!can_move) begin
								mode_d = MODE_IDLE;
								dir_d  = DIR_NONE;
							end else begin
								floor_d      = nf;
								move_stamp_d = now_s1;
								if (stop_n) begin
									cab_d   = cab_q & ~here_n;
									up_d    = up_q & ~here_n;
									dn_d    = dn_q & ~here_n;
									mode_d  = MODE_BLINK;
									tally_d = '0;
								end else if (!beyond_n) begin
									if (!(|all_c)) begin
										mode_d = MODE_IDLE;
										dir_d  = DIR_NONE;
									end else begin
										dir_d = (dir_q == DIR_UP) ? DIR_DESC : DIR_UP;
									end
								end
							end
						end
					end
					MODE_BLINK: begin
						if (tally_q == '0) begin
							blink_stamp_d = now_s1;
							lamp_d        = 1'b1;
							tally_d       = 5'd1;
						end else if (blink_due) begin
							lamp_d        = !lamp_q;
							blink_stamp_d = now_s1;
							tally_d       = tally_inc;
							if ({1'b0, tally_inc} > blink_limit) begin
								mode_d       = MODE_DOOR;
								door_stamp_d = now_s1;
							end
						end
					end
					default: begin
						if (door_due) begin
							mode_d = MODE_IDLE;
							lamp_d = 1'b0;
						end
					end
				endcase
			end
			OP_CABIN, OP_UP, OP_DOWN: begin
				if (floor_s1 == '0 || floor_s1 > FLOOR_TOP) begin
					rej_d = 1'b1;
				end else if (opcode_s1 == OP_CABIN) begin
					cab_d = cab_q | req_bit;
				end else if (opcode_s1 == OP_UP) begin
					up_d = up_q | req_bit;
				end else begin
					dn_d = dn_q | req_bit;
				end
			end
			OP_RESET: begin
				cab_d   = '0;
				up_d    = '0;
				dn_d    = '0;
				floor_d = FLOOR_BOTTOM;
				dir_d   = DIR_NONE;
				mode_d  = MODE_IDLE;
				tally_d = '0;
				lamp_d  = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cab_q         <= '0;
			up_q          <= '0;
			dn_q          <= '0;
			floor_q       <= FLOOR_BOTTOM;
			dir_q         <= DIR_NONE;
			mode_q        <= MODE_IDLE;
			move_stamp_q  <= '0;
			blink_stamp_q <= '0;
			door_stamp_q  <= '0;
			tally_q       <= '0;
			lamp_q        <= 1'b0;
		end else if (advance) begin
			cab_q         <= cab_d;
			up_q          <= up_d;
			dn_q          <= dn_d;
			floor_q       <= floor_d;
			dir_q         <= dir_d;
			mode_q        <= mode_d;
			move_stamp_q  <= move_stamp_d;
			blink_stamp_q <= blink_stamp_d;
			door_stamp_q  <= door_stamp_d;
			tally_q       <= tally_d;
			lamp_q        <= lamp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			floor_s2 <= floor_d;
			dir_s2   <= dir_d;
			mode_s2  <= mode_d;
			lamp_s2  <= lamp_d;
			rej_s2   <= rej_d;
			pend_s2  <= |(cab_d | up_d | dn_d);
		end
	end

	assign out_valid        = valid_s2;
	assign car_floor        = floor_s2;
	assign travel_direction = dir_s2;
	assign control_mode     = mode_s2;
	assign lamp_on          = lamp_s2;
	assign call_rejected    = rej_s2;
	assign calls_pending    = pend_s2;

	// car never leaves the shaft
	`ELC_ASSERT_ALWAYS(a_floor_range, floor_q >= FLOOR_BOTTOM && floor_q <= FLOOR_TOP,
		"car floor out of range")
	// moving always has a direction
	`ELC_ASSERT_NOW(a_move_dir, mode_q == MODE_MOVE, dir_q != DIR_NONE,
		"moving with no direction")
	// lamp only lit around an arrival
	`ELC_ASSERT_NOW(a_lamp_mode, lamp_q, mode_q == MODE_BLINK || mode_q == MODE_DOOR,
		"lamp lit outside arrival")
	// input only stalls with an event waiting in stage one
	`ELC_ASSERT_NOW(a_stall_full, in_stall, valid_s1,
		"input stalled with stage one empty")
	// every stage-one transfer produces a result
	`ELC_ASSERT_NEXT(a_result_follows, advance, valid_s2,
		"result missing after transfer")

endmodule

### tb/elevator_look_controller_top_tb.sv
// ----------------------------------------------------------------------------
// elevator_look_controller_top_tb
// Self-checking bench for the LOOK elevator controller. A behavioural model of
// the car (call vectors, floor, direction, mode, lamp and timers) predicts the
// status of every event transfer; results are compared field by field in
// order. Stimulus is a short directed run, then call-and-tick rides under
// several timing settings with random gaps, receiver hold-off and noise.
// ----------------------------------------------------------------------------
module elevator_look_controller_top_tb;
	import elc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CAR_FLOORS     = FLOORS_DEF;
	localparam int unsigned WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		floor_t at_floor;
		dir_t   dir;
		mode_t  mode;
		logic   lamp;
		logic   rejected;
		logic   pending;
	} car_status_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           cfg_wr_en = 1'b0;
	cfg_idx_t       cfg_index = REG_MOVE_TIME;
	logic [CFG_W-1:0] cfg_data = '0;
	logic           in_valid = 1'b0;
	logic           in_stall;
	opcode_t        opcode = OP_TICK;
	floor_t         floor_number = '0;
	stamp_t         now_ms = '0;
	logic           out_valid;
	logic           out_stall = 1'b0;
	floor_t         car_floor;
	dir_t           travel_direction;
	mode_t          control_mode;
	logic           lamp_on;
	logic           call_rejected;
	logic           calls_pending;

	// car model
	logic [31:0]    cabin_req = '0, up_req = '0, down_req = '0;
	floor_t         car_fl = FLOOR_BOTTOM;
	dir_t           car_dir = DIR_NONE;
	mode_t          car_mode = MODE_IDLE;
	stamp_t         move_ts = '0, blink_ts = '0, door_ts = '0;
	tally_t         flash_cnt = '0;
	logic           lamp_lit = 1'b0;
	logic [15:0]    move_ms = MOVE_TIME_RST;
	logic [15:0]    blink_ms = BLINK_INTV_RST;
	logic [3:0]     blink_cyc = BLINK_CYC_RST;
	logic [15:0]    door_ms = DOOR_TIME_RST;

	car_status_t    status_q[$];
	int unsigned    mismatches = 0;
	int unsigned    events_sent = 0;
	int unsigned    idle_cycles = 0;
	stamp_t         clock_ms = '0;
	bit             tx_idle_on = 1'b1;
	bit             rx_idle_on = 1'b1;
	int unsigned    rx_hold_req = 0;

	elevator_look_controller_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.opcode           (opcode),
		.floor_number     (floor_number),
		.now_ms           (now_ms),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.car_floor        (car_floor),
		.travel_direction (travel_direction),
		.control_mode     (control_mode),
		.lamp_on          (lamp_on),
		.call_rejected    (call_rejected),
		.calls_pending    (calls_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------- car model ----------------

	function automatic logic [31:0] floor_span();
		return ((32'd1 << CAR_FLOORS) - 32'd1) << 1;
	endfunction

	function automatic logic [31:0] floors_above(floor_t f);
		return floor_span() & ~((32'd2 << f) - 32'd1);
	endfunction

	function automatic logic [31:0] floors_below(floor_t f);
		return floor_span() & ((32'd1 << f) - 32'd1) & ~32'd1;
	endfunction

	function automatic logic [31:0] pending_set();
		return (cabin_req | up_req | down_req) & floor_span();
	endfunction

	function automatic bit calls_ahead();
		if (car_dir == DIR_UP)
			return (pending_set() & floors_above(car_fl)) != 0;
		if (car_dir == DIR_DESC)
			return (pending_set() & floors_below(car_fl)) != 0;
		return 1'b0;
	endfunction

	// hall calls against the direction only stop the car when nothing lies beyond
	function automatic bit stop_wanted();
		logic [31:0] b;
		bit ahead;
		b = 32'd1 << car_fl;
		ahead = calls_ahead();
		if ((cabin_req & b) != 0)
			return 1'b1;
		if (car_dir == DIR_UP)
			return (up_req & b) != 0 || ((down_req & b) != 0 && !ahead);
		if (car_dir == DIR_DESC)
			return (down_req & b) != 0 || ((up_req & b) != 0 && !ahead);
		return 1'b0;
	endfunction

	function automatic void start_arrival();
		logic [31:0] keep;
		keep = ~(32'd1 << car_fl);
		cabin_req &= keep;
		up_req &= keep;
		down_req &= keep;
		car_mode = MODE_BLINK;
		flash_cnt = '0;
	endfunction

	function automatic void advance_car(stamp_t now);
		case (car_mode)
		MODE_IDLE: begin
			if ((pending_set() & (32'd1 << car_fl)) != 0) begin
				start_arrival();
			end else if (pending_set() != 0) begin
				car_dir = ((pending_set() & floors_above(car_fl)) != 0) ? DIR_UP : DIR_DESC;
				car_mode = MODE_MOVE;
				move_ts = now;
			end else begin
				car_dir = DIR_NONE;
			end
		end
		MODE_MOVE: begin
			if (stamp_t'(now - move_ts) >= stamp_t'(move_ms)) begin
				if (car_dir == DIR_UP && car_fl < CAR_FLOORS) begin
					car_fl = car_fl + 5'd1;
				end else if (car_dir == DIR_DESC && car_fl > FLOOR_BOTTOM) begin
					car_fl = car_fl - 5'd1;
				end else begin
					car_mode = MODE_IDLE;
					car_dir = DIR_NONE;
					return;
				end
				move_ts = now;
				if (stop_wanted()) begin
					start_arrival();
				end else if (!calls_ahead()) begin
					if (pending_set() == 0) begin
						car_mode = MODE_IDLE;
						car_dir = DIR_NONE;
					end else begin
						car_dir = (car_dir == DIR_UP) ? DIR_DESC : DIR_UP;
					end
				end
			end
		end
		MODE_BLINK: begin
			if (flash_cnt == 0) begin
				blink_ts = now;
				lamp_lit = 1'b1;
				flash_cnt = 5'd1;
			end else if (stamp_t'(now - blink_ts) >= stamp_t'(blink_ms)) begin
				lamp_lit = ~lamp_lit;
				blink_ts = now;
				flash_cnt = flash_cnt + 5'd1;
				if (int'(flash_cnt) > 2 * int'(blink_cyc)) begin
					car_mode = MODE_DOOR;
					door_ts = now;
				end
			end
		end
		default: begin
			if (stamp_t'(now - door_ts) >= stamp_t'(door_ms)) begin
				car_mode = MODE_IDLE;
				lamp_lit = 1'b0;
			end
		end
		endcase
	endfunction

	function automatic car_status_t apply_event(opcode_t op, floor_t fl, stamp_t now);
		car_status_t s;
		logic rej;
		rej = 1'b0;
		case (op)
		OP_TICK: advance_car(now);
		OP_CABIN, OP_UP, OP_DOWN: begin
			if (fl == 0 || fl > CAR_FLOORS)
				rej = 1'b1;
			else if (op == OP_CABIN)
				cabin_req |= 32'd1 << fl;
			else if (op == OP_UP)
				up_req |= 32'd1 << fl;
			else
				down_req |= 32'd1 << fl;
		end
		OP_RESET: begin
			cabin_req = '0;
			up_req = '0;
			down_req = '0;
			car_fl = FLOOR_BOTTOM;
			car_dir = DIR_NONE;
			car_mode = MODE_IDLE;
			flash_cnt = '0;
			lamp_lit = 1'b0;
		end
		default: ;
		endcase
		s.at_floor = car_fl;
		s.dir = car_dir;
		s.mode = car_mode;
		s.lamp = lamp_lit;
		s.rejected = rej;
		s.pending = pending_set() != 0;
		return s;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// next tick time: mostly just past the wait of the current mode
	function automatic stamp_t next_now();
		logic [31:0] span;
		int unsigned r;
		case (car_mode)
		MODE_MOVE:  span = 32'(move_ms);
		MODE_BLINK: span = 32'(blink_ms);
		MODE_DOOR:  span = 32'(door_ms);
		default:    span = $urandom_range(0, 50);
		endcase
		r = $urandom_range(0, 99);
		if (r < 55)
			clock_ms += span + $urandom_range(0, 3);
		else if (r < 70)
			clock_ms += (span != 0) ? span - 32'd1 : 32'd0;
		else if (r < 85)
			clock_ms += $urandom_range(0, 3);
		else if (r < 97)
			clock_ms += $urandom_range(0, span);
		else
			clock_ms = $urandom();
		return clock_ms;
	endfunction

	task automatic send_event(opcode_t op, floor_t fl, stamp_t now);
		int unsigned gap;
		in_valid <= 1'b1;
		opcode <= op;
		floor_number <= fl;
		now_ms <= now;
		do @(posedge clk); while (in_stall);
		status_q.push_back(apply_event(op, fl, now));
		events_sent++;
		if (tx_idle_on) begin
			gap = gap_len();
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_call();
		send_event(opcode_t'($urandom_range(OP_CABIN, OP_DOWN)),
			floor_t'($urandom_range(1, CAR_FLOORS)), $urandom());
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
		REG_MOVE_TIME:  move_ms = val;
		REG_BLINK_INTV: blink_ms = val;
		REG_BLINK_CYC:  blink_cyc = val[3:0];
		REG_DOOR_TIME:  door_ms = val;
		default: ;
		endcase
	endtask

	task automatic set_timing(logic [15:0] mv, logic [15:0] bi, logic [15:0] bc,
			logic [15:0] dr);
		write_reg(REG_MOVE_TIME, mv);
		write_reg(REG_BLINK_INTV, bi);
		write_reg(REG_BLINK_CYC, bc);
		write_reg(REG_DOOR_TIME, dr);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// a ride: a few calls, then ticks until the car is idle and empty again or 150 steps pass
	task automatic ride();
		int unsigned steps;
		repeat ($urandom_range(1, 4)) send_call();
		steps = 0;
		while (steps < 150 && (car_mode != MODE_IDLE || pending_set() != 0)) begin
			if ($urandom_range(0, 99) < 8)
				send_call();
			else
				send_event(OP_TICK, floor_t'($urandom_range(0, 31)), next_now());
			steps++;
		end
	endtask

	task automatic run_traffic(int unsigned count);
		int unsigned target;
		target = events_sent + count;
		while (events_sent < target) begin
			if ($urandom_range(0, 99) < 80) begin
				ride();
			end else begin
				repeat ($urandom_range(1, 5))
					send_event(opcode_t'($urandom_range(0, 7)),
						floor_t'($urandom_range(0, 31)), $urandom());
			end
		end
	endtask

	// ---------------- tests ----------------

	// zero timing: every wait is over on the next tick, doors open after one toggle
	task automatic test_directed();
		set_timing(16'd0, 16'd0, 16'd0, 16'd0);
		send_event(OP_CABIN, 5'd0, 32'd0);
		send_event(OP_UP, 5'd17, 32'd0);
		send_event(OP_DOWN, 5'd31, 32'hFFFF_FFFF);
		send_event(opcode_t'(3'd5), 5'd3, 32'd0);
		send_event(opcode_t'(3'd6), 5'd16, 32'd0);
		send_event(opcode_t'(3'd7), 5'd31, 32'hFFFF_FFFF);
		send_event(OP_CABIN, 5'd1, 32'd0);           // call at the car floor while idle
		send_event(OP_TICK, 5'd0, 32'd0);
		send_event(OP_CABIN, 5'd3, 32'd0);           // registered during blinking
		send_event(OP_TICK, 5'd31, 32'hFFFF_FFFF);
		send_event(OP_TICK, 5'd0, 32'd0);
		send_event(OP_DOWN, 5'd2, 32'd0);            // against travel, call beyond it
		repeat (4) send_event(OP_TICK, 5'd0, 32'hFFFF_FFFF);
		repeat (5) send_event(OP_TICK, 5'd31, 32'd0);
		send_event(OP_UP, 5'd16, 32'd0);
		send_event(OP_DOWN, 5'd1, 32'hFFFF_FFFF);
		send_event(OP_RESET, 5'd31, 32'hFFFF_FFFF);
		send_event(OP_TICK, 5'd0, 32'hFFFF_FFFF);
		wait_drained();
	endtask

	task automatic test_default_timing();
		set_timing(MOVE_TIME_RST, BLINK_INTV_RST, 16'(BLINK_CYC_RST), DOOR_TIME_RST);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		run_traffic(400);
		wait_drained();
	endtask

	task automatic test_slowest_timing();
		set_timing(16'hFFFF, 16'hFFFF, 16'd15, 16'hFFFF);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b1;
		run_traffic(380);
		wait_drained();
	endtask

	task automatic test_fastest_timing();
		set_timing(16'd1, 16'd1, 16'd1, 16'd1);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b0;
		run_traffic(380);
		wait_drained();
	endtask

	// upper bits of the blink count data are ignored by the block
	task automatic test_random_timing();
		repeat (3) begin
			set_timing(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 800)),
				16'($urandom_range(0, 65535)), 16'($urandom_range(0, 4000)));
			tx_idle_on = 1'($urandom_range(0, 1));
			rx_idle_on = 1'($urandom_range(0, 1));
			run_traffic(130);
			wait_drained();
		end
	endtask

	// receiver holds off while the sender keeps offering, so the block fills up
	task automatic test_backpressure();
		set_timing(16'd20, 16'd5, 16'd2, 16'd30);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		rx_hold_req = 300;
		repeat (40) begin
			if ($urandom_range(0, 3) == 0)
				send_call();
			else
				send_event(OP_TICK, floor_t'($urandom_range(0, 31)), next_now());
		end
		wait_drained();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		run_traffic(200);
		wait_drained();
	endtask

	// ---------------- receiver, checker, watchdog ----------------

	initial begin : receiver
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (rx_hold_req != 0) begin
				stall_left = rx_hold_req;
				rx_hold_req = 0;
			end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 99) < 30) begin
				stall_left = gap_len();
			end
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : status_check
		car_status_t got;
		car_status_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {car_floor, travel_direction, control_mode, lamp_on, call_rejected,
				calls_pending};
			if (status_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: status transfer with nothing expected: %p", $realtime, got);
			end else begin
				want = status_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("%0t: status mismatch (exp/got) floor %0d/%0d dir %0d/%0d",
							$realtime, want.at_floor, got.at_floor, want.dir, got.dir);
						$display(" mode %0d/%0d lamp %0b/%0b rejected %0b/%0b pending %0b/%0b",
							want.mode, got.mode, want.lamp, got.lamp,
							want.rejected, got.rejected, want.pending, got.pending);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("elevator_look_controller_top_tb: errors");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_default_timing();
		test_slowest_timing();
		test_fastest_timing();
		test_random_timing();
		test_backpressure();
		wait_drained();
		if (mismatches == 0 && status_q.size() == 0)
			$display("elevator_look_controller_top_tb: clean");
		else
			$display("elevator_look_controller_top_tb: errors");
		$finish;
	end

endmodule

### sim.f
+incdir+sv
sv/elc_pkg.sv
sv/elevator_look_controller_top.sv
tb/elevator_look_controller_top_tb.sv
